// File: sv/hcld_pkg.sv
package hcld_pkg;

    localparam int unsigned KW_COUNT = 4;
    localparam int unsigned KW_MAX   = 8;

    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic [KW_COUNT-1:0] ALL_ALIVE = '1;

    typedef enum logic [2:0] {
        REPLY_PONG     = 3'd0,
        REPLY_IDENTITY = 3'd1,
        REPLY_VERSION  = 3'd2,
        REPLY_UPTIME   = 3'd3,
        REPLY_ERROR    = 3'd4
    } reply_code_t;

    typedef logic [7:0] kw_text_t [KW_MAX];

    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        '{8'h50, 8'h49, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h44, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h56, 8'h45, 8'h52, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h55, 8'h50, 8'h54, 8'h49, 8'h4D, 8'h45, 8'h3F, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd3, 3'd4, 3'd7};

    typedef struct packed {
        logic [KW_COUNT-1:0] alive;
        logic                zero_seen;
    } hcld_flags_t;

    typedef struct packed {
        logic        emit;
        reply_code_t code;
    } hcld_result_t;

endpackage

// File: sv/hcld_match.sv
module hcld_match #(
    parameter int unsigned LEN_W    = 6,
    parameter int unsigned LAST_LEN = 63
) (
    input  logic [7:0]           byte_in,
    input  logic [LEN_W-1:0]     char_count,
    input  hcld_pkg::hcld_flags_t flags,
    output logic [LEN_W-1:0]     char_count_next,
    output hcld_pkg::hcld_flags_t flags_next,
    output hcld_pkg::hcld_result_t result
);
    import hcld_pkg::*;

    logic [KW_COUNT-1:0] len_eq;
    logic [KW_COUNT-1:0] char_ok;
    logic [KW_COUNT-1:0] hit;
    reply_code_t         hit_code;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            len_eq[k]  = (char_count == LEN_W'(KW_LEN[k]));
            char_ok[k] = (char_count < LEN_W'(KW_LEN[k]))
                         && (KW_TEXT[k][char_count[2:0]] == byte_in);
        end
    end

    always_comb
    begin
        hit = flags.zero_seen ? flags.alive : (flags.alive & len_eq);
        priority if (hit[0])
            hit_code = REPLY_PONG;
        else if (hit[1])
            hit_code = REPLY_IDENTITY;
        else if (hit[2])
            hit_code = REPLY_VERSION;
        else if (hit[3])
            hit_code = REPLY_UPTIME;
        else
            hit_code = REPLY_ERROR;
    end

    always_comb
    begin
        char_count_next  = char_count;
        flags_next       = flags;
        result.emit      = 1'b0;
        result.code      = REPLY_ERROR;
        priority if (byte_in == BYTE_CR)
        begin
            result.emit = 1'b0;
        end
        else if (byte_in == BYTE_LF)
        begin
            result.emit          = 1'b1;
            result.code          = hit_code;
            char_count_next      = '0;
            flags_next.alive     = ALL_ALIVE;
            flags_next.zero_seen = 1'b0;
        end
        else if (char_count >= LEN_W'(LAST_LEN))
        begin
            result.emit          = 1'b1;
            result.code          = REPLY_ERROR;
            char_count_next      = '0;
            flags_next.alive     = ALL_ALIVE;
            flags_next.zero_seen = 1'b0;
        end
        else
        begin
            char_count_next = char_count + LEN_W'(1);
            if (!flags.zero_seen)
            begin
                if (byte_in == BYTE_ZERO)
                begin
                    flags_next.alive     = flags.alive & len_eq;
                    flags_next.zero_seen = 1'b1;
                end
                else
                begin
                    flags_next.alive = flags.alive & char_ok;
                end
            end
        end
    end

endmodule

// File: sv/host_command_line_decoder_unit.sv
// A byte is held in the input register until it advances; its reply is then registered.
// Throughput: one byte per cycle while the reply port takes its words; the keyword flag update
// is a single combinational step between the input register and the line state registers.
// Reset: rst_n clears the line state (empty line, all keywords alive, no zero byte) and
// empties the input and reply registers.
module host_command_line_decoder_unit #(
    parameter int unsigned LINE_CAPACITY = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] rx_byte,
    input  logic       rx_valid,
    output logic       rx_ready,
    output logic [2:0] reply_code,
    output logic       reply_valid,
    input  logic       reply_ready
);
    import hcld_pkg::*;

    localparam int unsigned LEN_W    = $clog2(LINE_CAPACITY);
    localparam int unsigned LAST_LEN = LINE_CAPACITY - 1;

    logic [7:0]       in_byte_reg;
    logic             in_valid_reg;
    logic [LEN_W-1:0] char_count_reg;
    logic [LEN_W-1:0] char_count_next;
    hcld_flags_t      flags_reg;
    hcld_flags_t      flags_next;
    hcld_result_t     result;
    reply_code_t      reply_code_reg;
    logic             reply_valid_reg;
    logic             reply_valid_next;
    logic             advance;

    hcld_match #(
        .LEN_W    (LEN_W),
        .LAST_LEN (LAST_LEN)
    ) u_match (
        .byte_in         (in_byte_reg),
        .char_count      (char_count_reg),
        .flags           (flags_reg),
        .char_count_next (char_count_next),
        .flags_next      (flags_next),
        .result          (result)
    );

    assign advance          = in_valid_reg && (!reply_valid_reg || reply_ready);
    assign rx_ready         = !in_valid_reg || advance;
    assign reply_valid_next = (advance && result.emit) || (reply_valid_reg && !reply_ready);
    assign reply_valid      = reply_valid_reg;
    assign reply_code       = reply_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            reply_valid_reg <= 1'b0;
            char_count_reg  <= '0;
            flags_reg.alive <= ALL_ALIVE;
            flags_reg.zero_seen <= 1'b0;
        end
        else
        begin
            reply_valid_reg <= reply_valid_next;
            if (rx_ready)
                in_valid_reg <= rx_valid;
            if (advance)
            begin
                char_count_reg <= char_count_next;
                flags_reg      <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && rx_ready)
            in_byte_reg <= rx_byte;
        if (advance && result.emit)
            reply_code_reg <= result.code;
    end

    a_len_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        char_count_reg <= LEN_W'(LAST_LEN))
        else $error("line length beyond capacity");

    a_zero_needs_text: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.zero_seen |-> (char_count_reg != '0))
        else $error("zero byte flag set on an empty line");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |-> (reply_code <= 3'(REPLY_ERROR)))
        else $error("reply code out of range");

    a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_byte_reg == BYTE_LF)
        |=> (char_count_reg == '0 && flags_reg.alive == ALL_ALIVE && !flags_reg.zero_seen))
        else $error("line feed did not clear the line");

endmodule
